>>> design/dtpr_pkg.sv
// types and constants for the delimited text packet receiver
// no dependencies; used by dtpr_ctrl and the top level
`timescale 1ns / 1ps
`default_nettype none
package dtpr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TAIL    = 2'd2
  } phase_t;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_START      = 2'd0;
  localparam logic [1:0] CFG_FIRST_END  = 2'd1;
  localparam logic [1:0] CFG_SECOND_END = 2'd2;

  localparam logic [7:0] START_RST      = 8'd64;
  localparam logic [7:0] FIRST_END_RST  = 8'd13;
  localparam logic [7:0] SECOND_END_RST = 8'd10;
  localparam logic [7:0] TERMINATOR     = 8'd0;

  localparam int         LEN_W   = 7;
  localparam logic [6:0] LEN_MAX = 7'd127;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       packet_ready;
    logic [6:0] packet_length;
    logic [1:0] receive_phase;
    logic       overflowed;
  } out_item_t;

  typedef struct packed {
    logic       is_read;
    logic       packet_ready;
    logic [6:0] packet_length;
    logic [1:0] receive_phase;
    logic       overflowed;
  } status_t;

endpackage
`default_nettype wire

>>> design/dtpr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module dtpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> design/dtpr_ctrl.sv
// framing control: config registers, receive phase, write pointer, flags
// drives the packet store ports; uses dtpr_pkg
`timescale 1ns / 1ps
`default_nettype none
module dtpr_ctrl #(
  parameter int STORE_BYTES = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           accept,
  input  wire dtpr_pkg::in_item_t             item,
  output logic                                mem_we,
  output logic      [$clog2(STORE_BYTES)-1:0] mem_waddr,
  output logic      [7:0]                     mem_wdata,
  output logic                                mem_re,
  output logic      [$clog2(STORE_BYTES)-1:0] mem_raddr,
  output dtpr_pkg::status_t                   status
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int HW = AW + 1;
  localparam int CW = (HW > 7) ? HW : 7;
  localparam int WW = (AW > 7) ? AW : 7;

  logic [7:0] start_r, first_end_r, second_end_r;
  dtpr_pkg::phase_t phase_r, phase_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [HW-1:0] hwm_r, hwm_nxt;
  logic ready_r, ready_nxt;
  logic ovf_r, ovf_nxt;
  logic store_byte, store_term;
  logic [HW-1:0] wp_inc;
  logic [WW-1:0] wp_ext;
  logic [CW-1:0] idx_ext, hwm_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= dtpr_pkg::START_RST;
      first_end_r  <= dtpr_pkg::FIRST_END_RST;
      second_end_r <= dtpr_pkg::SECOND_END_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        dtpr_pkg::CFG_START:      start_r      <= cfg_data;
        dtpr_pkg::CFG_FIRST_END:  first_end_r  <= cfg_data;
        dtpr_pkg::CFG_SECOND_END: second_end_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    wp_nxt     = wp_r;
    ready_nxt  = ready_r;
    ovf_nxt    = ovf_r;
    store_byte = 1'b0;
    store_term = 1'b0;
    if (accept) begin
      unique case (item.req_type)
        dtpr_pkg::REQ_BYTE: begin
          unique case (phase_r)
            dtpr_pkg::PH_IDLE: begin
              if (item.rx_byte == start_r && !ready_r) begin
                phase_nxt = dtpr_pkg::PH_PAYLOAD;
                wp_nxt    = '0;
                ovf_nxt   = 1'b0;
              end
            end
            dtpr_pkg::PH_PAYLOAD: begin
              if (item.rx_byte == first_end_r) begin
                phase_nxt = dtpr_pkg::PH_TAIL;
              end else if (wp_r < AW'(STORE_BYTES - 1)) begin
                store_byte = 1'b1;
                wp_nxt     = wp_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            dtpr_pkg::PH_TAIL: begin
              if (item.rx_byte == second_end_r) begin
                store_term = 1'b1;
                phase_nxt  = dtpr_pkg::PH_IDLE;
                ready_nxt  = 1'b1;
              end
            end
            default: phase_nxt = dtpr_pkg::PH_IDLE;
          endcase
        end
        dtpr_pkg::REQ_CLEAR: ready_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // entries at or above the high-water mark were never written and read as zero
  assign wp_inc  = HW'(wp_r) + 1'b1;
  assign hwm_nxt = ((store_byte || store_term) && wp_inc > hwm_r) ? wp_inc : hwm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtpr_pkg::PH_IDLE;
      wp_r    <= '0;
      hwm_r   <= '0;
      ready_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      hwm_r   <= hwm_nxt;
      ready_r <= ready_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign wp_ext  = WW'(wp_nxt);
  assign idx_ext = CW'(item.read_index);
  assign hwm_ext = CW'(hwm_r);

  // outputs
  always_comb begin
    mem_we    = store_byte || store_term;
    mem_waddr = wp_r;
    mem_wdata = store_term ? dtpr_pkg::TERMINATOR : item.rx_byte;
    mem_re    = accept && (item.req_type == dtpr_pkg::REQ_READ);
    mem_raddr = AW'(item.read_index);
    status.is_read       = mem_re && (idx_ext < hwm_ext);
    status.packet_ready  = ready_nxt;
    status.packet_length = (wp_ext > WW'(dtpr_pkg::LEN_MAX)) ? dtpr_pkg::LEN_MAX
                                                             : wp_ext[dtpr_pkg::LEN_W-1:0];
    status.receive_phase = phase_nxt;
    status.overflowed    = ovf_nxt;
  end

endmodule
`default_nettype wire

>>> design/delimited_text_packet_receiver.sv
// pipeline: an item's result passes the store read stage (s1) and then the output register
// throughput: one item per cycle while in_stall is low; every item does at most one access to the packet store ram
// reset: synchronous, active low; config returns to '@', CR, LF, receiver goes idle
// the store needs no clearing pass: a high-water mark makes unwritten entries read as zero
// top level; instantiates dtpr_ctrl and dtpr_ram, uses dtpr_pkg
`timescale 1ns / 1ps
`default_nettype none
module delimited_text_packet_receiver #(
  parameter int STORE_BYTES = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire dtpr_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dtpr_pkg::out_item_t       out_data
);

  localparam int AW = $clog2(STORE_BYTES);

  logic accept, s1_adv;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;
  dtpr_pkg::status_t status, s1_r;
  logic s1_v_r, s1_v_nxt, o_v_r, o_v_nxt;
  dtpr_pkg::out_item_t o_r, o_nxt;

  assign cfg_ready = 1'b1;

  assign s1_adv   = !o_v_r || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  dtpr_ctrl #(.STORE_BYTES(STORE_BYTES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .status    (status)
  );

  dtpr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    s1_v_nxt = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    o_v_nxt  = s1_adv ? s1_v_r : o_v_r;
    o_nxt.read_data     = s1_r.is_read ? mem_rdata : 8'd0;
    o_nxt.packet_ready  = s1_r.packet_ready;
    o_nxt.packet_length = s1_r.packet_length;
    o_nxt.receive_phase = s1_r.receive_phase;
    o_nxt.overflowed    = s1_r.overflowed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= status;
    end
    if (s1_adv && s1_v_r) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule
`default_nettype wire
